[sv/differential_odometry_target_bearing_macros.svh]
// Assertion macros shared by the odometry block.
`ifndef DIFFERENTIAL_ODOMETRY_TARGET_BEARING_MACROS_SVH
`define DIFFERENTIAL_ODOMETRY_TARGET_BEARING_MACROS_SVH

// Same-cycle implication.
`define DOTB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry assertion failed");

// Next-cycle implication.
`define DOTB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");

`endif

[sv/dotb_pkg.sv]
package dotb_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam int CNT_FIELD_W = 32;
	localparam int HEAD_W      = 16;
	localparam int IN_DATA_W   = 80;
	localparam int POS_W       = 24;
	localparam int DIST_W      = 24;
	localparam int ANG_W       = 14;
	localparam int OUT_DATA_W  = 88;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 24;
	localparam int IPT_W       = 16;

	// serial multiplier: magnitude A times magnitude B, one B bit per cycle
	localparam int MUL_A_W   = 41;
	localparam int MUL_B_W   = 25;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// square root: one result bit per cycle
	localparam int SQ_W     = 50;
	localparam int SQ_STEPS = SQ_W / 2;
	localparam int SQ_K_W   = $clog2(SQ_STEPS);
	localparam int ROOT_W   = 26;

	// CORDIC datapath
	localparam int CX_W = 34;
	localparam int CZ_W = 27;
	localparam logic signed [CX_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [CZ_W-1:0] DEG180_FINE = 27'sd11796480;
	localparam logic signed [27:0] DEG90_FINE = 28'sd5898240;

	localparam logic [MUL_A_W-1:0] T_LIMIT = 41'h100_0000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IPT      = 2'd2;

	typedef enum logic {
		CM_ROTATE,
		CM_VECTOR
	} cordic_mode_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_GO,
		ST_T_WAIT,
		ST_HRED,
		ST_ROT_GO,
		ST_ROT_WAIT,
		ST_Y_GO,
		ST_Y_WAIT,
		ST_X_GO,
		ST_X_WAIT,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_AT_GO,
		ST_AT_WAIT,
		ST_OUT
	} state_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [CZ_W-1:0] atan_fine(input logic [4:0] idx);
		logic signed [CZ_W-1:0] v;
		unique case (idx)
			5'd0:  v = 27'sd2949120;
			5'd1:  v = 27'sd1740967;
			5'd2:  v = 27'sd919879;
			5'd3:  v = 27'sd466945;
			5'd4:  v = 27'sd234379;
			5'd5:  v = 27'sd117304;
			5'd6:  v = 27'sd58666;
			5'd7:  v = 27'sd29335;
			5'd8:  v = 27'sd14668;
			5'd9:  v = 27'sd7334;
			5'd10: v = 27'sd3667;
			5'd11: v = 27'sd1833;
			5'd12: v = 27'sd917;
			5'd13: v = 27'sd458;
			5'd14: v = 27'sd229;
			5'd15: v = 27'sd115;
			5'd16: v = 27'sd57;
			5'd17: v = 27'sd29;
			5'd18: v = 27'sd14;
			5'd19: v = 27'sd7;
			5'd20: v = 27'sd4;
			5'd21: v = 27'sd2;
			5'd22: v = 27'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[sv/dotb_mul.sv]
// Shift-add multiplier, unsigned, one multiplier bit per cycle.
module dotb_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dotb_pkg::MUL_A_W-1:0]  a,
	input  logic [dotb_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [dotb_pkg::MUL_P_W-1:0]  p
);
	import dotb_pkg::*;

	logic [MUL_P_W-1:0]   a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [MUL_P_W-1:0]   p_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MUL_P_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= p_q + (b_q[0] ? a_q : '0);
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

[sv/dotb_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle, rounded.
module dotb_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dotb_pkg::SQ_W-1:0]    s,
	output logic                         done,
	output logic [dotb_pkg::ROOT_W-1:0]  root
);
	import dotb_pkg::*;

	logic [SQ_W-1:0]   n_q;
	logic [SQ_W-1:0]   r_q;
	logic [SQ_K_W-1:0] k_q;
	logic              busy_q;
	logic              done_q;
	logic [SQ_W-1:0]   bit_v;
	logic [SQ_W-1:0]   rb;

	assign bit_v = SQ_W'(1) << {k_q, 1'b0};
	assign rb    = r_q + bit_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= SQ_K_W'(SQ_STEPS - 1);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= s;
			r_q <= '0;
		end else if (busy_q) begin
			if (n_q >= rb) begin
				n_q <= n_q - rb;
				r_q <= (r_q >> 1) + bit_v;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	// round to nearest: remainder above root means the upper neighbor is closer
	assign root = ROOT_W'(r_q) + ROOT_W'(n_q > r_q);
	assign done = done_q;

endmodule

[sv/dotb_cordic.sv]
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring.
module dotb_cordic #(
	parameter int STEPS = dotb_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dotb_pkg::cordic_cmd_t              cmd,
	input  logic signed [dotb_pkg::CX_W-1:0]   x0,
	input  logic signed [dotb_pkg::CX_W-1:0]   y0,
	input  logic signed [dotb_pkg::CZ_W-1:0]   z0,
	output logic                               done,
	output logic signed [dotb_pkg::CX_W-1:0]   x,
	output logic signed [dotb_pkg::CX_W-1:0]   y,
	output logic signed [dotb_pkg::CZ_W-1:0]   z
);
	import dotb_pkg::*;

	localparam int N    = (STEPS > 24) ? 24 : STEPS;
	localparam int IW   = $clog2(N);

	logic signed [CX_W-1:0] x_q, y_q;
	logic signed [CZ_W-1:0] z_q;
	logic [IW-1:0]          i_q;
	cordic_mode_t           mode_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [CX_W-1:0] xs, ys;
	logic signed [CZ_W-1:0] ang;
	logic                   pos;

	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign ang = atan_fine(5'(i_q));
	assign pos = (mode_q == CM_ROTATE) ? (z_q >= 0) : (y_q <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			mode_q <= CM_ROTATE;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				mode_q <= cmd.mode;
			end else if (busy_q) begin
				if (i_q == IW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (pos) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

[sv/differential_odometry_target_bearing.sv]
// Differential-drive odometry with distance and bearing to a target.
// Input stream (s_axis): one sample per transfer, left/right encoder counts and
// gyro heading. Output stream (m_axis): one result per sample, position,
// distance to target and bearing 90 - atan2(dy,dx) in 1/16 degree.
// Config port: cfg_we/cfg_addr/cfg_data write target_x (0), target_y (1),
// inches_per_tick (2); write only while no sample is in flight.
// The first sample after reset latches the reference counts, no position update.
// Per sample the sequencer runs the shared shift-add multiplier (five
// products), heading reduction, two CORDIC runs and the square root; the
// bearing CORDIC run is skipped when dx is zero, and the first sample runs
// only the distance products, the square root and the bearing step.
// s_axis_tready is high only when idle, so a new sample is accepted only after
// the previous one has reached the output register. The result sits in an
// output register, so the next sample is accepted while it waits; if the
// receiver stalls two results, the sequencer holds in its final state and
// s_axis_tready stays low.
// Reset (asynchronous, active low) clears position, reference flag, the
// output valid and restores the register reset values.
module differential_odometry_target_bearing #(
	parameter int CORDIC_STEPS = dotb_pkg::CORDIC_STEPS_DEF,
	parameter int COUNT_WIDTH  = dotb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// left_count[31:0], right_count[63:32], heading[79:64]
	input  logic [dotb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pos_x[23:0], pos_y[47:24], target_distance[71:48], target_angle[85:72], zero pad
	output logic [dotb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [dotb_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [dotb_pkg::CFG_W-1:0]          cfg_data
);
	import dotb_pkg::*;

	`include "differential_odometry_target_bearing_macros.svh"

	state_t state_q, state_d;

	// config
	logic signed [POS_W-1:0] target_x_q, target_y_q;
	logic [IPT_W-1:0]        ipt_q;

	// odometry state
	logic [COUNT_WIDTH-1:0]  prev_left_q, prev_right_q;
	logic signed [POS_W-1:0] acc_x_q, acc_y_q;
	logic                    have_ref_q;

	// per-sample working registers
	logic [COUNT_WIDTH:0]    diff_mag_q;
	logic                    diff_neg_q;
	logic [MUL_A_W-1:0]      t_mag_q;
	logic signed [16:0]      m_q;
	logic                    fold_neg_q;
	logic [19:0]             c_mag_q, s_mag_q;
	logic                    c_neg_q, s_neg_q;
	logic signed [POS_W:0]   dx_q, dy_q;
	logic [SQ_W-1:0]         sum_q;
	logic [DIST_W-1:0]       dist_q;
	logic signed [ANG_W-1:0] ang_q;

	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_s1;

	// sub-unit hookup
	logic                    mul_start, mul_done;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [MUL_P_W-1:0]      mul_p;
	cordic_cmd_t             cor_cmd;
	logic signed [CX_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
	logic signed [CZ_W-1:0]  cor_z0, cor_z;
	logic                    cor_done;
	logic                    sq_start, sq_done;
	logic [ROOT_W-1:0]       sq_root;

	logic                    in_xfer, out_xfer, out_load;

	// sample decode and count deltas (wrap at COUNT_WIDTH bits)
	logic [COUNT_WIDTH-1:0]  l_in, r_in, dl_u, dr_u;
	logic signed [COUNT_WIDTH:0] diff;
	logic signed [HEAD_W-1:0] head_in;

	assign l_in    = s_axis_tdata[COUNT_WIDTH-1:0];
	assign r_in    = s_axis_tdata[CNT_FIELD_W+COUNT_WIDTH-1:CNT_FIELD_W];
	assign head_in = s_axis_tdata[2*CNT_FIELD_W+HEAD_W-1:2*CNT_FIELD_W];
	assign dl_u    = l_in - prev_left_q;
	assign dr_u    = r_in - prev_right_q;
	assign diff    = $signed({dl_u[COUNT_WIDTH-1], dl_u}) - $signed({dr_u[COUNT_WIDTH-1], dr_u});

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	// heading reduction to [-180,180) degrees
	logic hred_hi, hred_lo;
	assign hred_hi = (m_q >= 17'sd2880);
	assign hred_lo = (m_q < -17'sd2880);

	// position to target
	logic signed [POS_W:0] dx_c, dy_c;
	assign dx_c = $signed({target_x_q[POS_W-1], target_x_q}) - $signed({acc_x_q[POS_W-1], acc_x_q});
	assign dy_c = $signed({target_y_q[POS_W-1], target_y_q}) - $signed({acc_y_q[POS_W-1], acc_y_q});

	function automatic logic [POS_W:0] mag25(input logic signed [POS_W:0] v);
		return v[POS_W] ? (POS_W+1)'(0) - v : v;
	endfunction

	// trig value: Q30 -> Q16, rounded half away from zero
	function automatic logic [19:0] q16_mag(input logic signed [CX_W-1:0] v);
		logic [CX_W-1:0] m;
		logic [CX_W-1:0] r;
		m = v[CX_W-1] ? CX_W'(0) - v : v;
		r = m + CX_W'(8192);
		return r[33:14];
	endfunction

	// position delta = round(T*trig / 2^25), saturating add into a 24-bit axis
	function automatic logic signed [POS_W-1:0] acc_add(input logic signed [POS_W-1:0] acc,
			input logic [MUL_P_W-1:0] p, input logic neg);
		logic [MUL_P_W-1:0]  pr;
		logic signed [34:0]  d, sum;
		pr  = p + (MUL_P_W'(1) << 24);
		d   = $signed({2'b00, pr[57:25]});
		if (neg)
			d = -d;
		sum = d + 35'(acc);
		if (sum > 35'sd8388607)
			return 24'sh7FFFFF;
		else if (sum < -35'sd8388608)
			return 24'sh800000;
		else
			return sum[POS_W-1:0];
	endfunction

	// bearing = round((90deg - atan) / 4096), clamped to [-1440,4320]
	function automatic logic signed [ANG_W-1:0] bearing(input logic signed [CZ_W-1:0] z);
		logic signed [27:0] v;
		logic [27:0]        m, r;
		logic signed [17:0] a;
		v = DEG90_FINE - 28'(z);
		m = v[27] ? 28'd0 - v : v;
		r = m + 28'd2048;
		a = $signed({2'b00, r[27:12]});
		if (v[27])
			a = -a;
		if (a > 18'sd4320)
			return 14'sd4320;
		else if (a < -18'sd1440)
			return -14'sd1440;
		else
			return a[ANG_W-1:0];
	endfunction

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_axis_tvalid) state_d = have_ref_q ? ST_T_GO : ST_DX_GO;
			ST_T_GO:     state_d = ST_T_WAIT;
			ST_T_WAIT:   if (mul_done) state_d = ST_HRED;
			ST_HRED:     if (!hred_hi && !hred_lo) state_d = ST_ROT_GO;
			ST_ROT_GO:   state_d = ST_ROT_WAIT;
			ST_ROT_WAIT: if (cor_done) state_d = ST_Y_GO;
			ST_Y_GO:     state_d = ST_Y_WAIT;
			ST_Y_WAIT:   if (mul_done) state_d = ST_X_GO;
			ST_X_GO:     state_d = ST_X_WAIT;
			ST_X_WAIT:   if (mul_done) state_d = ST_DX_GO;
			ST_DX_GO:    state_d = ST_DX_WAIT;
			ST_DX_WAIT:  if (mul_done) state_d = ST_DY_GO;
			ST_DY_GO:    state_d = ST_DY_WAIT;
			ST_DY_WAIT:  if (mul_done) state_d = ST_SQ_GO;
			ST_SQ_GO:    state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:  if (sq_done) state_d = ST_AT_GO;
			ST_AT_GO:    state_d = (dx_q == '0) ? ST_OUT : ST_AT_WAIT;
			ST_AT_WAIT:  if (cor_done) state_d = ST_OUT;
			ST_OUT:      if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		s_axis_tready = 1'b0;
		mul_start     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		cor_cmd.start = 1'b0;
		cor_cmd.mode  = CM_ROTATE;
		cor_x0        = CORDIC_K;
		cor_y0        = '0;
		cor_z0        = CZ_W'(m_q) <<< 12;
		sq_start      = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_T_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(diff_mag_q);
				mul_b     = MUL_B_W'(ipt_q);
			end
			ST_ROT_GO: cor_cmd.start = 1'b1;
			ST_Y_GO: begin
				mul_start = 1'b1;
				mul_a     = t_mag_q;
				mul_b     = MUL_B_W'(c_mag_q);
			end
			ST_X_GO: begin
				mul_start = 1'b1;
				mul_a     = t_mag_q;
				mul_b     = MUL_B_W'(s_mag_q);
			end
			ST_DX_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(mag25(dx_c));
				mul_b     = MUL_B_W'(mag25(dx_c));
			end
			ST_DY_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(mag25(dy_q));
				mul_b     = MUL_B_W'(mag25(dy_q));
			end
			ST_SQ_GO:  sq_start = 1'b1;
			ST_AT_GO: begin
				cor_cmd.start = (dx_q != '0);
				cor_cmd.mode  = CM_VECTOR;
				// left half plane: turn by 180 degrees first
				cor_x0 = dx_q[POS_W] ? -(CX_W'(dx_q) <<< 6) : (CX_W'(dx_q) <<< 6);
				cor_y0 = dx_q[POS_W] ? -(CX_W'(dy_q) <<< 6) : (CX_W'(dy_q) <<< 6);
				cor_z0 = dx_q[POS_W] ? (dy_q[POS_W] ? -DEG180_FINE : DEG180_FINE) : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ---------------- config registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= 24'sd38579;
			ipt_q      <= 16'd2292;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_TARGET_X: target_x_q <= cfg_data;
				CFG_TARGET_Y: target_y_q <= cfg_data;
				CFG_IPT:      ipt_q      <= cfg_data[IPT_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- odometry state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			have_ref_q   <= 1'b0;
		end else begin
			if (in_xfer) begin
				prev_left_q  <= l_in;
				prev_right_q <= r_in;
				have_ref_q   <= 1'b1;
			end
			if (state_q == ST_Y_WAIT && mul_done)
				acc_y_q <= acc_add(acc_y_q, mul_p, diff_neg_q ^ c_neg_q);
			if (state_q == ST_X_WAIT && mul_done)
				acc_x_q <= acc_add(acc_x_q, mul_p, diff_neg_q ^ s_neg_q);
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			diff_neg_q <= diff[COUNT_WIDTH];
			diff_mag_q <= diff[COUNT_WIDTH] ? (COUNT_WIDTH+1)'(0) - diff : diff;
			m_q        <= 17'(head_in);
		end
		if (state_q == ST_T_WAIT && mul_done)
			t_mag_q <= (mul_p > MUL_P_W'(T_LIMIT)) ? T_LIMIT : mul_p[MUL_A_W-1:0];
		if (state_q == ST_HRED) begin
			if (hred_hi)
				m_q <= m_q - 17'sd5760;
			else if (hred_lo)
				m_q <= m_q + 17'sd5760;
			else if (m_q > 17'sd1440) begin
				// fold into [-90,90] degrees, trig results negated
				m_q        <= m_q - 17'sd2880;
				fold_neg_q <= 1'b1;
			end else if (m_q < -17'sd1440) begin
				m_q        <= m_q + 17'sd2880;
				fold_neg_q <= 1'b1;
			end else begin
				fold_neg_q <= 1'b0;
			end
		end
		if (state_q == ST_ROT_WAIT && cor_done) begin
			c_mag_q <= q16_mag(cor_x);
			s_mag_q <= q16_mag(cor_y);
			c_neg_q <= cor_x[CX_W-1] ^ fold_neg_q;
			s_neg_q <= cor_y[CX_W-1] ^ fold_neg_q;
		end
		if (state_q == ST_DX_GO) begin
			dx_q <= dx_c;
			dy_q <= dy_c;
		end
		if (state_q == ST_DX_WAIT && mul_done)
			sum_q <= mul_p[SQ_W-1:0];
		if (state_q == ST_DY_WAIT && mul_done)
			sum_q <= sum_q + mul_p[SQ_W-1:0];
		if (state_q == ST_SQ_WAIT && sq_done)
			dist_q <= (sq_root > ROOT_W'(24'hFFFFFF)) ? 24'hFFFFFF : sq_root[DIST_W-1:0];
		if (state_q == ST_AT_GO)
			ang_q <= '0;
		if (state_q == ST_AT_WAIT && cor_done)
			ang_q <= bearing(cor_z);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_xfer)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_data_s1 <= {2'b00, ang_q, dist_q, acc_y_q, acc_x_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_s1;

	// ---------------- units ----------------
	dotb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	dotb_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cor_cmd),
		.x0     (cor_x0),
		.y0     (cor_y0),
		.z0     (cor_z0),
		.done   (cor_done),
		.x      (cor_x),
		.y      (cor_y),
		.z      (cor_z)
	);

	dotb_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.s      (sum_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// ---------------- assertions ----------------
	`DOTB_ASSERT_NEXT(a_ref_sticky, clk, arst_n, have_ref_q, have_ref_q)
	`DOTB_ASSERT_NEXT(a_first_skips_motion, clk, arst_n, in_xfer && !have_ref_q, state_q == ST_DX_GO)
	`DOTB_ASSERT_NOW(a_mul_done_waited, clk, arst_n, mul_done, state_q == ST_T_WAIT || state_q == ST_Y_WAIT || state_q == ST_X_WAIT || state_q == ST_DX_WAIT || state_q == ST_DY_WAIT)
	`DOTB_ASSERT_NOW(a_cordic_done_waited, clk, arst_n, cor_done, state_q == ST_ROT_WAIT || state_q == ST_AT_WAIT)
	`DOTB_ASSERT_NEXT(a_stall_holds_result, clk, arst_n, state_q == ST_OUT && out_valid_q && !m_axis_tready, state_q == ST_OUT)

endmodule

[bench/tb_differential_odometry_target_bearing.sv]
`timescale 1ns / 100ps

// Odometry block bench: a queue-fed driver pushes encoder/heading samples into
// the input stream, a monitor checks each output transfer against a software
// model of the position update, distance and bearing computed at acceptance.
module tb_differential_odometry_target_bearing;
	import dotb_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;   // cycles with no transfer at all
	localparam int SETTLE_CYCLES  = 400;     // longer than one sample's processing

	typedef struct packed {
		logic [15:0] heading;
		logic [31:0] right_count;
		logic [31:0] left_count;
	} sample_t;

	typedef struct packed {
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic [23:0] distance;
		logic [13:0] angle;
	} fix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = CFG_TARGET_X;
	logic [CFG_W-1:0]      cfg_data = '0;

	differential_odometry_target_bearing dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	sample_t pending_samples[$];
	fix_t    expected_fixes[$];
	int      sender_idle_pct = 0;
	int      receiver_stall_pct = 0;
	int      mismatches = 0;
	int      fixes_checked = 0;
	int      samples_sent = 0;
	int      quiet_cycles = 0;

	// model copy of the block's state and registers
	logic [31:0] odo_prev_left = '0, odo_prev_right = '0;
	longint      odo_x = 0, odo_y = 0;
	bit          odo_have_ref = 0;
	longint      tgt_x = 0, tgt_y = 38579, tick_scale = 2292;

	function automatic longint rnd_shift(longint v, int n);
		longint half;
		half = 64'sd1 << (n - 1);
		if (v >= 0) return (v + half) >>> n;
		return -(((-v) + half) >>> n);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint arc_step(int i);
		case (i)
			0: return 2949120;  1: return 1740967;  2: return 919879;  3: return 466945;
			4: return 234379;   5: return 117304;   6: return 58666;   7: return 29335;
			8: return 14668;    9: return 7334;     10: return 3667;   11: return 1833;
			12: return 917;     13: return 458;     14: return 229;    15: return 115;
			16: return 57;      17: return 29;      18: return 14;     19: return 7;
			20: return 4;       21: return 2;       22: return 1;
			default: return 0;
		endcase
	endfunction

	// heading in 1/16 deg -> sin, cos in Q16 via rotation-mode CORDIC
	task automatic heading_trig(input longint h, output longint s, output longint c);
		longint m, x, y, z, xs, ys;
		bit flip;
		m = h % 5760;
		x = 652032874;
		y = 0;
		flip = 0;
		if (m >= 2880) m -= 5760;
		if (m < -2880) m += 5760;
		if (m > 1440) begin
			m -= 2880; flip = 1;
		end else if (m < -1440) begin
			m += 2880; flip = 1;
		end
		z = m * 4096;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arc_step(i);
			end else begin
				x += ys; y -= xs; z += arc_step(i);
			end
		end
		x = rnd_shift(x, 14);
		y = rnd_shift(y, 14);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// atan2 in 1/65536 deg, vectoring mode, dx nonzero
	function automatic longint bearing_fine(longint dy, longint dx);
		longint x, y, z, xs, ys;
		x = dx * 64;
		y = dy * 64;
		z = 0;
		if (dx < 0) begin
			x = -x; y = -y;
			z = (dy >= 0) ? 64'sd11796480 : -64'sd11796480;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += arc_step(i);
			end else begin
				x -= ys; y += xs; z -= arc_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned root_nearest(longint unsigned s);
		longint unsigned r, b, n;
		r = 0;
		b = 64'd1 << 62;
		n = s;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	// advance model state for one accepted sample, queue the expected fix
	task automatic predict_fix(input sample_t smp);
		longint dl, dr, t, s, c, dx, dy, dist_v, ang;
		fix_t f;
		if (odo_have_ref) begin
			dl = longint'(int'(smp.left_count - odo_prev_left));
			dr = longint'(int'(smp.right_count - odo_prev_right));
			t = clamp((dl - dr) * tick_scale, -(64'sd1 << 40), 64'sd1 << 40);
			heading_trig(longint'($signed(smp.heading)), s, c);
			odo_y = clamp(odo_y + rnd_shift(t * c, 25), -8388608, 8388607);
			odo_x = clamp(odo_x + rnd_shift(t * s, 25), -8388608, 8388607);
		end
		odo_prev_left = smp.left_count;
		odo_prev_right = smp.right_count;
		odo_have_ref = 1;
		dx = tgt_x - odo_x;
		dy = tgt_y - odo_y;
		dist_v = longint'(root_nearest(longint'(dx * dx + dy * dy)));
		if (dist_v > 16777215) dist_v = 16777215;
		if (dx == 0) ang = 0;
		else ang = clamp(rnd_shift(64'sd5898240 - bearing_fine(dy, dx), 12), -1440, 4320);
		f.pos_x = odo_x[23:0];
		f.pos_y = odo_y[23:0];
		f.distance = dist_v[23:0];
		f.angle = ang[13:0];
		expected_fixes.push_back(f);
	endtask

	// driver: one NBA per signal per edge; prediction taken on the transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_fix(sample_t'(s_axis_tdata));
				samples_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_samples.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, compare each output transfer
	always @(posedge clk) begin
		fix_t want;
		fix_t got;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				got.pos_x = m_axis_tdata[23:0];
				got.pos_y = m_axis_tdata[47:24];
				got.distance = m_axis_tdata[71:48];
				got.angle = m_axis_tdata[85:72];
				if (expected_fixes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected output transfer %h", m_axis_tdata);
				end else begin
					want = expected_fixes.pop_front();
					fixes_checked++;
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR fix %0d: exp x=%0d y=%0d d=%0d a=%0d got x=%0d y=%0d d=%0d a=%0d",
								fixes_checked, $signed(want.pos_x), $signed(want.pos_y),
								want.distance, $signed(want.angle), $signed(got.pos_x),
								$signed(got.pos_y), got.distance, $signed(got.angle));
					end
				end
			end
		end
	end

	// watchdog on a stalled pipeline
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	logic [31:0] gen_left = '0, gen_right = '0;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TARGET_X: tgt_x = longint'($signed(val[23:0]));
			CFG_TARGET_Y: tgt_y = longint'($signed(val[23:0]));
			CFG_IPT:      tick_scale = longint'(val[15:0]);
			default: ;
		endcase
	endtask

	task automatic queue_sample(input logic [31:0] l, input logic [31:0] r, input logic [15:0] h);
		sample_t smp;
		smp.left_count = l;
		smp.right_count = r;
		smp.heading = h;
		gen_left = l;
		gen_right = r;
		pending_samples.push_back(smp);
	endtask

	// mostly small wheel moves from the last counts; some wide jumps
	task automatic queue_random(input int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			if (kind == 0)
				queue_sample($urandom, $urandom, 16'($urandom));
			else if (kind == 1)
				queue_sample(gen_left + $urandom_range(2000000) - 1000000,
					gen_right + $urandom_range(2000000) - 1000000, 16'($urandom));
			else
				queue_sample(gen_left + $urandom_range(4000) - 2000,
					gen_right + $urandom_range(4000) - 2000, 16'($urandom));
		end
	endtask

	task automatic drain(input int idle_s, input int stall_r);
		sender_idle_pct = idle_s;
		receiver_stall_pct = stall_r;
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_fixes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reference sample, heading quadrants and wrap, count wrap
		queue_sample(32'h7FFF_FFF0, 32'h8000_0010, 16'h8000);
		queue_sample(32'h8000_0100, 32'h7FFF_FF00, 16'd0);      // wrap on both counts
		queue_sample(32'h8000_0400, 32'h7FFF_FC00, 16'd1440);
		queue_sample(32'h8000_0800, 32'h7FFF_F800, -16'sd1440);
		queue_sample(32'h8000_0C00, 32'h7FFF_F400, 16'd2880);
		queue_sample(32'h8000_1000, 32'h7FFF_F000, -16'sd2880);
		queue_sample(32'h8000_1400, 32'h7FFF_EC00, 16'd5760);
		queue_sample(32'h8000_1800, 32'h7FFF_E800, 16'h7FFF);
		queue_sample(32'h8000_1800, 32'h7FFF_E800, 16'h8000);   // no motion
		queue_sample(32'h0000_0000, 32'hFFFF_FFFF, 16'd1441);
		queue_sample(32'hFFFF_FFFF, 32'h0000_0000, -16'sd1441);
		queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 16'd720);    // both deltas -2^31, no net motion
		queue_sample(32'h0000_0000, 32'h0000_0000, -16'sd4320);
		queue_sample(32'h0000_1000, 32'hFFFF_F000, 16'd4320);
		queue_sample(32'h0000_1000, 32'hFFFF_F000, 16'd0);
		drain(0, 0);

		write_reg(CFG_TARGET_X, -8388608);
		write_reg(CFG_TARGET_Y, 8388607);
		write_reg(CFG_IPT, 65535);
		queue_random(100);
		drain(87, 0);

		write_reg(CFG_TARGET_X, 8388607);
		write_reg(CFG_TARGET_Y, -8388608);
		write_reg(CFG_IPT, 1);
		queue_random(100);
		drain(0, 87);

		write_reg(CFG_TARGET_X, $urandom_range(16777215));
		write_reg(CFG_TARGET_Y, $urandom_range(16777215));
		write_reg(CFG_IPT, $urandom_range(65535, 1));
		queue_random(100);
		drain(33, 33);

		// target on the current position axis to hit dx zero again
		write_reg(CFG_TARGET_X, odo_x);
		write_reg(CFG_TARGET_Y, 0);
		write_reg(CFG_IPT, 2292);
		queue_sample(gen_left + 100, gen_right - 100, 16'd0);
		queue_sample(gen_left + 100, gen_right - 100, 16'd2880);
		queue_random(100);
		drain(0, 0);

		write_reg(CFG_TARGET_X, $urandom_range(16777215));
		write_reg(CFG_TARGET_Y, $urandom_range(16777215));
		write_reg(CFG_IPT, $urandom_range(65535, 1));
		queue_random(100);
		drain(33, 33);

		$display("Checked %0d position fixes from %0d samples over six register settings,",
			fixes_checked, samples_sent);
		$display("with sender gaps and receiver backpressure; %0d mismatches.", mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
